@@ src/urf_pkg.sv @@
// shared types and constants of the ultrasonic range filter
package urf_pkg;

  // field widths
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned DIST_W   = 14;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // pulse width to q4 centimetres: (width * 281) >> 10
  localparam int unsigned CONV_MUL   = 281;
  localparam int unsigned MUL_W      = 9;
  localparam int unsigned CONV_SHIFT = 10;
  localparam int unsigned PROD_W     = WIDTH_W + MUL_W;

  localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
  localparam logic [WIDTH_W-1:0] TIMEOUT_RESET = 16'd30000;
  localparam logic [DIST_W-1:0]  THRESH_RESET  = 14'd800;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESH = 1'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } urf_state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ src/urf_div.sv @@
// restoring divider, one quotient bit per cycle
module urf_div #(
  parameter int unsigned DIVIDEND_W = 17,
  parameter int unsigned DIVISOR_W  = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output logic [DIVIDEND_W-1:0]  quotient,
  output urf_pkg::div_status_t   status
);
  import urf_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVIDEND_W-1:0] quo_next;
  logic [DIVISOR_W-1:0]  dsr;
  logic [STEP_W-1:0]     steps;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  // one trial subtraction
  always_comb begin
    shifted  = {rem, quo[DIVIDEND_W-1]};
    fits     = (shifted >= {1'b0, dsr});
    rem_next = fits ? DIVISOR_W'(shifted - {1'b0, dsr}) : DIVISOR_W'(shifted);
    quo_next = {quo[DIVIDEND_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      dsr   <= divisor;
      steps <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      rem   <= rem_next;
      quo   <= quo_next;
      steps <= steps - STEP_W'(1);
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ src/ultrasonic_range_filter.sv @@
// echo pulse to distance conversion with a moving mean over a sample ring
//
//  channel  direction  handshake            payload
//  in       into       in_valid / in_stall  echo_width_us
//  out      out of     out_valid/out_stall  raw_distance, filtered_distance,
//                                           object_near, echo_timed_out
//  cfg      into       cfg_write            cfg_index, cfg_data
//
// one transaction at a time: accept, multiply, ring write, summing over the
// RING_DEPTH slots, divider start, then the divider takes one quotient bit per
// cycle and signals done with the quotient; the result is then loaded into the
// output register and the sequencer returns to idle to take the next input.
// An all-zero ring skips the divider.
// in_stall stays high until the result is in the output register; a stalled
// result holds and the next input is taken meanwhile, its result then waits.
// rst is synchronous and resets the configuration registers, the ring write
// pointer and fill flag, out_valid and the sequencer; data registers are not.
module ultrasonic_range_filter #(
  parameter int unsigned RING_DEPTH = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [urf_pkg::WIDTH_W-1:0]     echo_width_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [urf_pkg::DIST_W-1:0]      raw_distance,
  output logic [urf_pkg::DIST_W-1:0]      filtered_distance,
  output logic                            object_near,
  output logic                            echo_timed_out,
  input  logic                            cfg_write,
  input  logic [urf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [urf_pkg::CFG_W-1:0]       cfg_data
);
  import urf_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = DIST_W + CNT_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  urf_state_t state;
  urf_state_t state_next;

  logic [WIDTH_W-1:0] echo_timeout_us;
  logic [DIST_W-1:0]  detect_threshold;

  logic [DIST_W-1:0]  ring [RING_DEPTH];
  logic [IDX_W-1:0]   write_slot;
  logic               ring_filled;

  logic [WIDTH_W-1:0] width;
  logic [PROD_W-1:0]  prod;
  logic               timed_out;
  logic [DIST_W-1:0]  raw;
  logic [DIST_W-1:0]  raw_next;
  logic               near;
  logic [PROD_W-CONV_SHIFT-1:0] dist_full;

  logic [IDX_W-1:0]   sum_idx;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [DIST_W-1:0]  mean;

  logic               div_start;
  logic [SUM_W-1:0]   div_quotient;
  div_status_t        div_status;
  logic               out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_timeout_us  <= TIMEOUT_RESET;
      detect_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ECHO_TIMEOUT:  echo_timeout_us  <= cfg_data;
        REG_DETECT_THRESH: detect_threshold <= cfg_data[DIST_W-1:0];
      endcase
    end
  end

  // scaled distance with saturation, zero on echo timeout
  always_comb begin
    dist_full = prod[PROD_W-1:CONV_SHIFT];
    if (timed_out) begin
      raw_next = '0;
    end else if (dist_full > {1'b0, DIST_MAX}) begin
      raw_next = DIST_MAX;
    end else begin
      raw_next = dist_full[DIST_W-1:0];
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_SUM;
      ST_SUM: begin
        if (sum_idx == LAST_SLOT) state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        if (count == '0) begin
          state_next = ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_status.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      ring_filled <= 1'b0;
    end else if (state == ST_WRITE) begin
      ring_filled <= 1'b1;
      write_slot  <= (write_slot == LAST_SLOT) ? '0 : write_slot + IDX_W'(1);
    end
  end

  // ring entries: the first sample fills every slot
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (!ring_filled || write_slot == IDX_W'(i)) ring[i] <= raw_next;
      end
    end
  end

  // per-sample datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        width <= echo_width_us;
      end
      ST_CONV: begin
        prod      <= PROD_W'(width) * PROD_W'(CONV_MUL);
        timed_out <= (width > echo_timeout_us);
      end
      ST_WRITE: begin
        raw     <= raw_next;
        near    <= (raw_next != '0) && (raw_next <= detect_threshold);
        sum_idx <= '0;
        sum     <= '0;
        count   <= '0;
      end
      ST_SUM: begin
        sum_idx <= sum_idx + IDX_W'(1);
        if (ring[sum_idx] != '0) begin
          sum   <= sum + SUM_W'(ring[sum_idx]);
          count <= count + CNT_W'(1);
        end
      end
      ST_DIV_START: begin
        mean <= '0;
      end
      ST_DIV_WAIT: begin
        if (div_status.done) mean <= div_quotient[DIST_W-1:0];
      end
      ST_FINISH: begin
        mean <= mean;
      end
      default: begin
        mean <= mean;
      end
    endcase
  end

  // divider for the mean
  urf_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (count),
    .quotient(div_quotient),
    .status  (div_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      raw_distance      <= raw;
      filtered_distance <= mean;
      object_near       <= near;
      echo_timed_out    <= timed_out;
    end
  end

endmodule

@@ src/urf_checker.sv @@
// port level checks of the ultrasonic range filter and their binding
module urf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [urf_pkg::DIST_W-1:0]    raw_distance,
  input logic                          object_near,
  input logic                          echo_timed_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a sample is in work");

  // no echo means no distance and no detection
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && echo_timed_out |-> raw_distance == '0 && !object_near)
    else $error("timed out sample carries a distance or detection");

  // detection needs a real distance
  a_near_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && object_near |-> raw_distance != '0)
    else $error("detection flagged on zero distance");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_range_filter urf_checker u_urf_checker (.*);
